[rtl/core/isl_pkg.sv]
// ----------------------------------------------------------------------------
// isl_pkg
// Types and codes shared by the indexed shift list modules.
// ----------------------------------------------------------------------------
package isl_pkg;

  // operation carried by each input beat
  typedef enum logic [3:0] {
    OP_PUSH_TAIL  = 4'd0,
    OP_PUSH_HEAD  = 4'd1,
    OP_POP_TAIL   = 4'd2,
    OP_POP_HEAD   = 4'd3,
    OP_INSERT     = 4'd4,
    OP_REMOVE     = 4'd5,
    OP_WRITE      = 4'd6,
    OP_READ       = 4'd7,
    OP_CLEAR      = 4'd8
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_BADIDX = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    CTL_IDLE = 1'b0,
    CTL_EXEC = 1'b1
  } ctl_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic load;    // capture the incoming beat
    logic commit;  // execute the held item and load the result register
  } isl_cmd_t;

  localparam int unsigned ModeW   = 4;
  localparam int unsigned IndexW  = 8;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned ReadW   = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 5;
  localparam int unsigned InTdataW  = 48;
  localparam int unsigned OutTdataW = 40;
  localparam int unsigned PosW    = 9;  // wide enough for any index or count

endpackage

[rtl/core/isl_ctrl.sv]
// ----------------------------------------------------------------------------
// isl_ctrl
// Sequencer for the indexed shift list: takes a beat, executes it once the
// result register is free, and tracks the result register's valid flag.
// ----------------------------------------------------------------------------
module isl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  output logic              m_tvalid,
  input  logic              m_tready,
  output isl_pkg::isl_cmd_t cmd
);

  isl_pkg::ctl_state_t state, state_next;
  logic                out_valid, out_valid_next;
  logic                slot_free;

  assign slot_free = !out_valid || m_tready;

  always_comb begin
    state_next = state;
    case (state)
      isl_pkg::CTL_IDLE: begin
        if (s_tvalid) state_next = isl_pkg::CTL_EXEC;
      end
      isl_pkg::CTL_EXEC: begin
        if (slot_free) state_next = isl_pkg::CTL_IDLE;
      end
      default: state_next = isl_pkg::CTL_IDLE;
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.commit = 1'b0;
    case (state)
      isl_pkg::CTL_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      isl_pkg::CTL_EXEC: begin
        cmd.commit = slot_free;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.commit) out_valid_next = 1'b1;
    else if (m_tready) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= isl_pkg::CTL_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign m_tvalid = out_valid;

`ifndef ASSERT_OFF
  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == isl_pkg::CTL_EXEC)
    else $error("accepted beat not followed by execution");

  a_commit_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> m_tvalid)
    else $error("executed item gave no result beat");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_tready |-> !cmd.commit)
    else $error("waiting result overwritten");

  a_no_take_in_exec: assert property (@(posedge clk) disable iff (rst)
    state == isl_pkg::CTL_EXEC |-> !s_tready && !cmd.load)
    else $error("beat taken while an item is held");
`endif

endmodule

[rtl/core/isl_dp.sv]
// ----------------------------------------------------------------------------
// isl_dp
// Datapath of the indexed shift list: entry registers, count, held item and
// result register. Inserts and removes shift the affected entries in parallel.
// ----------------------------------------------------------------------------
module isl_dp #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  isl_pkg::isl_cmd_t                   cmd,
  input  logic [isl_pkg::ModeW-1:0]           mode,
  input  logic [isl_pkg::IndexW-1:0]          index,
  input  logic [isl_pkg::ValueW-1:0]          value,
  output logic [isl_pkg::ReadW-1:0]           read_value,
  output logic [isl_pkg::StatusW-1:0]         status,
  output logic [isl_pkg::CountW-1:0]          count
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned PosW = isl_pkg::PosW;
  localparam logic [PosW-1:0] CapPos = PosW'(CAPACITY);

  // held item
  logic [isl_pkg::ModeW-1:0]  mode_q;
  logic [isl_pkg::IndexW-1:0] index_q;
  logic [DATA_WIDTH-1:0]      value_q;

  logic [DATA_WIDTH-1:0] store      [CAPACITY];
  logic [DATA_WIDTH-1:0] store_next [CAPACITY];
  logic [DATA_WIDTH-1:0] up_src     [CAPACITY];
  logic [DATA_WIDTH-1:0] dn_src     [CAPACITY];
  logic [CntW-1:0]       entry_count, entry_count_next;

  logic [isl_pkg::ReadW-1:0] res_read;
  isl_pkg::status_t          res_status;
  logic [CntW-1:0]           res_count;

  logic [PosW-1:0]       cnt_pos, idx_pos, pos;
  logic                  do_ins, do_rm, do_wr, do_clr, rd_en;
  isl_pkg::status_t      st;
  logic [DATA_WIDTH-1:0] rd;

  // neighbours of each entry for up and down shifts
  for (genvar g = 0; g < CAPACITY; g++) begin : g_src
    if (g == 0) begin : g_first
      assign up_src[g] = '0;
    end else begin : g_up
      assign up_src[g] = store[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign dn_src[g] = '0;
    end else begin : g_dn
      assign dn_src[g] = store[g+1];
    end
  end

  assign cnt_pos = PosW'(entry_count);
  assign idx_pos = PosW'(index_q);

  // decode the operation against the current count
  always_comb begin
    st     = isl_pkg::ST_OK;
    pos    = '0;
    do_ins = 1'b0;
    do_rm  = 1'b0;
    do_wr  = 1'b0;
    do_clr = 1'b0;
    rd_en  = 1'b0;
    entry_count_next = entry_count;
    case (isl_pkg::op_t'(mode_q))
      isl_pkg::OP_PUSH_TAIL: begin
        if (cnt_pos >= CapPos) st = isl_pkg::ST_FULL;
        else begin
          do_ins = 1'b1;
          pos    = cnt_pos;
        end
      end
      isl_pkg::OP_PUSH_HEAD: begin
        if (cnt_pos >= CapPos) st = isl_pkg::ST_FULL;
        else do_ins = 1'b1;
      end
      isl_pkg::OP_POP_TAIL: begin
        if (cnt_pos == '0) st = isl_pkg::ST_EMPTY;
        else entry_count_next = CntW'(cnt_pos - PosW'(1));
      end
      isl_pkg::OP_POP_HEAD: begin
        if (cnt_pos == '0) st = isl_pkg::ST_EMPTY;
        else do_rm = 1'b1;
      end
      isl_pkg::OP_INSERT: begin
        if (idx_pos > cnt_pos) st = isl_pkg::ST_BADIDX;
        else if (cnt_pos >= CapPos) st = isl_pkg::ST_FULL;
        else begin
          do_ins = 1'b1;
          pos    = idx_pos;
        end
      end
      isl_pkg::OP_REMOVE: begin
        if (idx_pos >= cnt_pos) st = isl_pkg::ST_BADIDX;
        else begin
          do_rm = 1'b1;
          pos   = idx_pos;
        end
      end
      isl_pkg::OP_WRITE: begin
        if (idx_pos >= CapPos) st = isl_pkg::ST_BADIDX;
        else begin
          do_wr = 1'b1;
          if (idx_pos >= cnt_pos) entry_count_next = CntW'(idx_pos + PosW'(1));
        end
      end
      isl_pkg::OP_READ: begin
        if (idx_pos >= CapPos) st = isl_pkg::ST_BADIDX;
        else rd_en = 1'b1;
      end
      isl_pkg::OP_CLEAR: begin
        do_clr = 1'b1;
        entry_count_next = '0;
      end
      default: begin
        st = isl_pkg::ST_OK;
      end
    endcase
    if (do_ins) entry_count_next = CntW'(cnt_pos + PosW'(1));
    if (do_rm)  entry_count_next = CntW'(cnt_pos - PosW'(1));
  end

  // per-entry next value and read select
  always_comb begin
    rd = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      store_next[i] = store[i];
      if (do_clr) begin
        store_next[i] = '0;
      end else if (do_ins) begin
        if (PosW'(i) == pos) store_next[i] = value_q;
        else if (PosW'(i) > pos && PosW'(i) <= cnt_pos) store_next[i] = up_src[i];
      end else if (do_rm) begin
        if (PosW'(i) >= pos && PosW'(i) + PosW'(1) < cnt_pos) store_next[i] = dn_src[i];
      end else if (do_wr && PosW'(i) == idx_pos) begin
        store_next[i] = value_q;
      end
      if (rd_en && PosW'(i) == idx_pos) rd = rd | store[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_q  <= mode;
      index_q <= index;
      value_q <= DATA_WIDTH'(value);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      for (int i = 0; i < CAPACITY; i++) store[i] <= '0;
    end else if (cmd.commit) begin
      entry_count <= entry_count_next;
      for (int i = 0; i < CAPACITY; i++) store[i] <= store_next[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_read   <= isl_pkg::ReadW'(rd);
      res_status <= st;
      res_count  <= entry_count_next;
    end
  end

  assign read_value = res_read;
  assign status     = res_status;
  assign count      = isl_pkg::CountW'(res_count);

endmodule

[rtl/core/indexed_shift_list.sv]
// ----------------------------------------------------------------------------
// indexed_shift_list
// Fixed-capacity ordered list with push, pop, insert, remove, write, read
// and clear; one result beat per input beat.
//
//   channel | dir | tdata fields (lsb first)
//   s_*     | in  | mode[3:0], index[11:4], value[43:12], zero pad
//   m_*     | out | read_value[31:0], status[33:32], count[38:34], zero pad
//
// an item is handled in order: the beat is captured, then the item is executed
// against the entry registers, and its result goes into the result register
// inserts and removes shift the affected entries in parallel in the execute cycle
// a new beat is taken while the previous result still waits on m_tready
// execution stalls only while the result register holds an untaken beat
// rst synchronously clears the entry registers and the count at the end of a reset cycle
// ----------------------------------------------------------------------------
module indexed_shift_list #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [isl_pkg::InTdataW-1:0]    s_tdata,   // mode, index, value
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [isl_pkg::OutTdataW-1:0]   m_tdata    // read_value, status, count
);

  isl_pkg::isl_cmd_t                  cmd;
  logic [isl_pkg::ReadW-1:0]          read_value;
  logic [isl_pkg::StatusW-1:0]        status;
  logic [isl_pkg::CountW-1:0]         count;

  isl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  isl_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .mode       (s_tdata[3:0]),
    .index      (s_tdata[11:4]),
    .value      (s_tdata[43:12]),
    .read_value (read_value),
    .status     (status),
    .count      (count)
  );

  assign m_tdata = {1'b0, count, status, read_value};

endmodule

[test/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed shift list testbench
// Streams list operations into the block and checks every result beat against
// a shadow copy of the entry registers and count, kept in step at each
// accepted input beat. Random gaps on both sides, one long output back-off and
// two pauses of the input until all results are back.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CAPACITY    = 16;
  localparam int unsigned RANDOM_OPS  = 1100;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned IDLE_PCT    = 36;

  typedef struct {
    logic [isl_pkg::ModeW-1:0]  mode;
    logic [isl_pkg::IndexW-1:0] index;
    logic [isl_pkg::ValueW-1:0] value;
    bit                         drain_first;  // hold back until all results are in
  } list_item_t;

  typedef struct {
    logic [isl_pkg::ReadW-1:0]  read_value;
    isl_pkg::status_t           status;
    logic [isl_pkg::CountW-1:0] count;
  } list_result_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [isl_pkg::InTdataW-1:0]  s_tdata = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [isl_pkg::OutTdataW-1:0] m_tdata;

  list_item_t   pending_ops[$];
  list_result_t expected_results[$];
  list_item_t   offered;
  bit           offer_done = 1'b0;

  logic [isl_pkg::ValueW-1:0] model_entries[CAPACITY];
  int                         model_count = 0;

  int unsigned cycle_count     = 0;
  int unsigned items_accepted  = 0;
  int unsigned results_checked = 0;
  int unsigned mismatch_count  = 0;
  int unsigned stall_left      = 0;
  bit          long_stall_done = 1'b0;
  bit          calm;

  indexed_shift_list #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(32)
  ) i_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // no idling on either side while this window of beats goes through
  assign calm = (items_accepted >= 700) && (items_accepted < 950);

  // shadow list: apply one operation and return the result it should give
  function automatic list_result_t apply_list_op(input list_item_t it);
    list_result_t r;
    int           idx;
    r.read_value = '0;
    r.status     = isl_pkg::ST_OK;
    idx          = int'(it.index);
    case (it.mode)
      isl_pkg::OP_PUSH_TAIL, isl_pkg::OP_PUSH_HEAD: begin
        if (model_count >= CAPACITY) begin
          r.status = isl_pkg::ST_FULL;
        end else if (it.mode == isl_pkg::OP_PUSH_TAIL) begin
          model_entries[model_count] = it.value;
          model_count++;
        end else begin
          for (int i = model_count; i > 0; i--) model_entries[i] = model_entries[i-1];
          model_entries[0] = it.value;
          model_count++;
        end
      end
      isl_pkg::OP_POP_TAIL: begin
        if (model_count == 0) r.status = isl_pkg::ST_EMPTY;
        else model_count--;
      end
      isl_pkg::OP_POP_HEAD: begin
        if (model_count == 0) begin
          r.status = isl_pkg::ST_EMPTY;
        end else begin
          for (int i = 0; i + 1 < model_count; i++) model_entries[i] = model_entries[i+1];
          model_count--;
        end
      end
      isl_pkg::OP_INSERT: begin
        // index check takes priority over the full check
        if (idx > model_count) begin
          r.status = isl_pkg::ST_BADIDX;
        end else if (model_count >= CAPACITY) begin
          r.status = isl_pkg::ST_FULL;
        end else begin
          for (int i = model_count; i > idx; i--) model_entries[i] = model_entries[i-1];
          model_entries[idx] = it.value;
          model_count++;
        end
      end
      isl_pkg::OP_REMOVE: begin
        if (idx >= model_count) begin
          r.status = isl_pkg::ST_BADIDX;
        end else begin
          for (int i = idx; i + 1 < model_count; i++) model_entries[i] = model_entries[i+1];
          model_count--;
        end
      end
      isl_pkg::OP_WRITE: begin
        if (idx >= CAPACITY) begin
          r.status = isl_pkg::ST_BADIDX;
        end else begin
          model_entries[idx] = it.value;
          if (idx >= model_count) model_count = idx + 1;
        end
      end
      isl_pkg::OP_READ: begin
        if (idx >= CAPACITY) r.status = isl_pkg::ST_BADIDX;
        else r.read_value = model_entries[idx];
      end
      isl_pkg::OP_CLEAR: begin
        foreach (model_entries[i]) model_entries[i] = '0;
        model_count = 0;
      end
      default: ;
    endcase
    r.count = model_count[isl_pkg::CountW-1:0];
    return r;
  endfunction

  function automatic void queue_op(input logic [isl_pkg::ModeW-1:0] mode,
                                   input int index,
                                   input logic [isl_pkg::ValueW-1:0] value,
                                   input bit drain = 1'b0);
    list_item_t it;
    it.mode        = mode;
    it.index       = index[isl_pkg::IndexW-1:0];
    it.value       = value;
    it.drain_first = drain;
    pending_ops.insert(pending_ops.size(), it);
  endfunction

  // growing phases favour pushes and inserts, shrinking ones pops and removes
  function automatic void queue_random_op(input bit growing, input bit drain);
    int unsigned pick;
    int unsigned idx;
    logic [isl_pkg::ModeW-1:0] mode;
    pick = $urandom_range(99);
    idx  = ($urandom_range(99) < 6) ? $urandom_range(255) : $urandom_range(17);
    if (pick < 2) begin
      mode = isl_pkg::OP_CLEAR;
    end else if (pick < 4) begin
      mode = 4'($urandom_range(15, 9));
    end else if (growing) begin
      if      (pick < 25) mode = isl_pkg::OP_PUSH_TAIL;
      else if (pick < 42) mode = isl_pkg::OP_PUSH_HEAD;
      else if (pick < 62) mode = isl_pkg::OP_INSERT;
      else if (pick < 72) mode = isl_pkg::OP_WRITE;
      else if (pick < 84) mode = isl_pkg::OP_READ;
      else if (pick < 90) mode = isl_pkg::OP_REMOVE;
      else if (pick < 95) mode = isl_pkg::OP_POP_TAIL;
      else                mode = isl_pkg::OP_POP_HEAD;
    end else begin
      if      (pick < 22) mode = isl_pkg::OP_POP_TAIL;
      else if (pick < 42) mode = isl_pkg::OP_POP_HEAD;
      else if (pick < 62) mode = isl_pkg::OP_REMOVE;
      else if (pick < 78) mode = isl_pkg::OP_READ;
      else if (pick < 84) mode = isl_pkg::OP_WRITE;
      else if (pick < 90) mode = isl_pkg::OP_INSERT;
      else                mode = isl_pkg::OP_PUSH_TAIL;
    end
    queue_op(mode, idx, $urandom(), drain);
  endfunction

  initial begin
    bit growing;
    foreach (model_entries[i]) model_entries[i] = '0;

    // directed: empty list, shifting, stale data, full list, bad indexes, unused modes, clear
    queue_op(isl_pkg::OP_READ, 0, 32'h0);
    queue_op(isl_pkg::OP_POP_TAIL, 0, 32'h0);
    queue_op(isl_pkg::OP_POP_HEAD, 0, 32'h0);
    queue_op(isl_pkg::OP_REMOVE, 0, 32'h0);
    queue_op(isl_pkg::OP_INSERT, 1, 32'h1);
    queue_op(isl_pkg::OP_PUSH_TAIL, 0, 32'hFFFF_FFFF);
    queue_op(isl_pkg::OP_PUSH_HEAD, 0, 32'h0000_0000);
    queue_op(isl_pkg::OP_INSERT, 2, 32'hA5A5_A5A5);
    queue_op(isl_pkg::OP_INSERT, 1, 32'h5A5A_5A5A);
    queue_op(isl_pkg::OP_REMOVE, 1, 32'h0);
    queue_op(isl_pkg::OP_POP_HEAD, 0, 32'h0);
    queue_op(isl_pkg::OP_POP_TAIL, 0, 32'h0);
    queue_op(isl_pkg::OP_WRITE, 3, 32'h1234_5678);
    queue_op(isl_pkg::OP_READ, 2, 32'h0);
    queue_op(isl_pkg::OP_READ, 9, 32'h0);
    queue_op(isl_pkg::OP_WRITE, 15, 32'hDEAD_BEEF);
    queue_op(isl_pkg::OP_PUSH_TAIL, 0, 32'h1111_1111);
    queue_op(isl_pkg::OP_PUSH_HEAD, 0, 32'h2222_2222);
    queue_op(isl_pkg::OP_INSERT, 17, 32'h3333_3333);
    queue_op(isl_pkg::OP_INSERT, 0, 32'h4444_4444);
    queue_op(isl_pkg::OP_REMOVE, 15, 32'h0);
    queue_op(isl_pkg::OP_READ, 255, 32'h0);
    queue_op(isl_pkg::OP_WRITE, 16, 32'h5555_5555);
    queue_op(isl_pkg::OP_WRITE, 255, 32'h6666_6666);
    queue_op(4'd9, 0, 32'h0);
    queue_op(4'd15, 255, 32'hFFFF_FFFF);
    queue_op(isl_pkg::OP_CLEAR, 0, 32'h0);
    queue_op(isl_pkg::OP_READ, 15, 32'h0);

    growing = 1'b1;
    for (int i = 0; i < RANDOM_OPS; i++) begin
      if (i % 40 == 0) growing = ($urandom_range(99) < 55);
      queue_random_op(growing, (i == 500) || (i == 1000));
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pending_ops.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);

    $display("%0d operations accepted, %0d result beats checked, %0d mismatches",
             items_accepted, results_checked, mismatch_count);
    $display("covered pushes, pops, inserts, removes, writes, reads, clears and unused modes");
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // input side: take the beat into the shadow list when it is accepted
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready && !offer_done) begin
      expected_results.insert(expected_results.size(), apply_list_op(offered));
      items_accepted++;
      offer_done = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || offer_done) begin
      if (pending_ops.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT) &&
          !(pending_ops[0].drain_first && expected_results.size() != 0)) begin
        offered    = pending_ops[0];
        pending_ops.delete(0);
        offer_done = 1'b0;
        s_tvalid  <= 1'b1;
        s_tdata   <= {4'b0000, offered.value, offered.index, offered.mode};
      end else begin
        s_tvalid  <= 1'b0;
      end
    end
  end

  // output side: back-pressure, with one long hold-off to fill the block
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (!long_stall_done && results_checked >= 400) begin
        long_stall_done = 1'b1;
        stall_left      = 150;
      end
      if (stall_left != 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    list_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("result beat with nothing expected: tdata %h", m_tdata);
        mismatch_count++;
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        results_checked++;
        if (m_tdata[31:0] !== want.read_value) begin
          $error("read_value: expected %h, actual %h", want.read_value, m_tdata[31:0]);
          mismatch_count++;
        end
        if (m_tdata[33:32] !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, m_tdata[33:32]);
          mismatch_count++;
        end
        if (m_tdata[38:34] !== want.count) begin
          $error("count: expected %0d, actual %0d", want.count, m_tdata[38:34]);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timed out after %0d cycles, %0d results still expected",
               cycle_count, expected_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

endmodule
